@@ sv/otcc_pkg.sv @@
// Shared types and constants for the obstacle table collision checker.
// Used by otcc_ctrl, otcc_datapath, obstacle_table_collision_check and the testbench; no dependencies.
package otcc_pkg;

   localparam int COORD_W = 16;
   localparam int RAD_W   = 15;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_SEG   = 2'd2;
   localparam logic [1:0] OP_POINT = 2'd3;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic [RAD_W-1:0]          circle_radius;
   } req_type;

   typedef struct packed {
      logic path_free;
      logic add_dropped;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_query;
      logic write_entry;
      logic issue;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pipe_busy;
      logic hit_any;
   } status_type;

endpackage

@@ sv/otcc_datapath.sv @@
// Datapath: circle table memory and the pipelined segment/point versus circle test.
// Depends on otcc_pkg.
module otcc_datapath #(
   parameter int MAX_CIRCLES = 64,
   parameter int IDX_W       = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  otcc_pkg::req_type    req,
   input  otcc_pkg::cmd_type    cmd,
   input  logic [IDX_W-1:0]     addr,
   output otcc_pkg::status_type status
);

   localparam int CW = otcc_pkg::COORD_W;
   localparam int RW = otcc_pkg::RAD_W;
   localparam int DW = CW + 1;        // differences
   localparam int PW = 2 * DW;        // single products
   localparam int SW = PW + 2;        // sums of products
   localparam int HW = SW / 2;        // half of a split operand
   localparam int WW = 2 * SW;        // wide products

   // Circle table.
   logic signed [CW-1:0] mem_x [MAX_CIRCLES];
   logic signed [CW-1:0] mem_y [MAX_CIRCLES];
   logic [RW-1:0]        mem_r [MAX_CIRCLES];

   // Query registers, stable while a query runs.
   logic signed [CW-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [DW-1:0] dx_ff, dy_ff;
   logic                 point_ff;
   logic                 hit_any_ff;
   logic [5:0]           vld_ff;

   // Stage 0: table read.
   logic signed [CW-1:0] cx0_ff, cy0_ff;
   logic [RW-1:0]        r0_ff;
   // Stage 1: differences and radius square.
   logic signed [DW-1:0] fx1_ff, fy1_ff, gx1_ff, gy1_ff;
   logic [2*RW-1:0]      rsq1_ff;
   // Stage 2: products.
   logic signed [PW-1:0] pfx2_ff, pfy2_ff, pgx2_ff, pgy2_ff;
   logic signed [PW-1:0] phx2_ff, phy2_ff, pdx2_ff, pdy2_ff;
   logic [2*RW-1:0]      rsq2_ff;
   // Stage 3: quadratic terms.
   logic signed [SW-1:0] q03_ff, q13_ff, a3_ff, h3_ff;
   // Stage 4: flags and partial products.
   logic                 q0neg4_ff, q1neg4_ff, q0z4_ff, q1z4_ff, hneg4_ff, ahneg4_ff;
   logic signed [2*HW-1:0] hh_hh4_ff, aq_hh4_ff;
   logic signed [2*HW:0]   hh_hl4_ff, aq_hl4_ff, aq_lh4_ff;
   logic [2*HW-1:0]        hh_ll4_ff, aq_ll4_ff;
   // Stage 5: summed wide products.
   logic                 q0neg5_ff, q1neg5_ff, q0z5_ff, q1z5_ff, hneg5_ff, ahneg5_ff;
   logic signed [WW-1:0] hh5_ff, aq5_ff;

   logic signed [WW-1:0] disc;
   logic                 seg_hit, pnt_hit, hit;
   logic signed [SW-1:0] ah_sum;

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         mem_x[addr] <= req.first_x;
         mem_y[addr] <= req.first_y;
         mem_r[addr] <= req.circle_radius;
      end
      if (cmd.issue) begin
         cx0_ff <= mem_x[addr];
         cy0_ff <= mem_y[addr];
         r0_ff  <= mem_r[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         sx_ff    <= req.first_x;
         sy_ff    <= req.first_y;
         ex_ff    <= req.second_x;
         ey_ff    <= req.second_y;
         dx_ff    <= DW'(req.second_x) - DW'(req.first_x);
         dy_ff    <= DW'(req.second_y) - DW'(req.first_y);
         // A zero-length segment is answered as a point query.
         point_ff <= (req.op == otcc_pkg::OP_POINT) ||
                     ((req.first_x == req.second_x) && (req.first_y == req.second_y));
      end
   end

   always_ff @(posedge clock) begin
      fx1_ff  <= DW'(sx_ff) - DW'(cx0_ff);
      fy1_ff  <= DW'(sy_ff) - DW'(cy0_ff);
      gx1_ff  <= DW'(ex_ff) - DW'(cx0_ff);
      gy1_ff  <= DW'(ey_ff) - DW'(cy0_ff);
      rsq1_ff <= (2*RW)'(r0_ff) * (2*RW)'(r0_ff);

      pfx2_ff <= PW'(fx1_ff) * PW'(fx1_ff);
      pfy2_ff <= PW'(fy1_ff) * PW'(fy1_ff);
      pgx2_ff <= PW'(gx1_ff) * PW'(gx1_ff);
      pgy2_ff <= PW'(gy1_ff) * PW'(gy1_ff);
      phx2_ff <= PW'(fx1_ff) * PW'(dx_ff);
      phy2_ff <= PW'(fy1_ff) * PW'(dy_ff);
      pdx2_ff <= PW'(dx_ff) * PW'(dx_ff);
      pdy2_ff <= PW'(dy_ff) * PW'(dy_ff);
      rsq2_ff <= rsq1_ff;

      q03_ff <= SW'(pfx2_ff) + SW'(pfy2_ff) - SW'({1'b0, rsq2_ff});
      q13_ff <= SW'(pgx2_ff) + SW'(pgy2_ff) - SW'({1'b0, rsq2_ff});
      a3_ff  <= SW'(pdx2_ff) + SW'(pdy2_ff);
      h3_ff  <= SW'(phx2_ff) + SW'(phy2_ff);

      // Split each operand into a signed high half and an unsigned low half.
      q0neg4_ff <= q03_ff[SW-1];
      q1neg4_ff <= q13_ff[SW-1];
      q0z4_ff   <= (q03_ff == '0);
      q1z4_ff   <= (q13_ff == '0);
      hneg4_ff  <= h3_ff[SW-1];
      ahneg4_ff <= ah_sum[SW-1];
      hh_hh4_ff <= (2*HW)'($signed(h3_ff[SW-1:HW])) * (2*HW)'($signed(h3_ff[SW-1:HW]));
      hh_hl4_ff <= (2*HW+1)'($signed(h3_ff[SW-1:HW])) *
                   (2*HW+1)'($signed({1'b0, h3_ff[HW-1:0]}));
      hh_ll4_ff <= (2*HW)'(h3_ff[HW-1:0]) * (2*HW)'(h3_ff[HW-1:0]);
      aq_hh4_ff <= (2*HW)'($signed(a3_ff[SW-1:HW])) * (2*HW)'($signed(q03_ff[SW-1:HW]));
      aq_hl4_ff <= (2*HW+1)'($signed(a3_ff[SW-1:HW])) *
                   (2*HW+1)'($signed({1'b0, q03_ff[HW-1:0]}));
      aq_lh4_ff <= (2*HW+1)'($signed(q03_ff[SW-1:HW])) *
                   (2*HW+1)'($signed({1'b0, a3_ff[HW-1:0]}));
      aq_ll4_ff <= (2*HW)'(a3_ff[HW-1:0]) * (2*HW)'(q03_ff[HW-1:0]);

      q0neg5_ff <= q0neg4_ff;
      q1neg5_ff <= q1neg4_ff;
      q0z5_ff   <= q0z4_ff;
      q1z5_ff   <= q1z4_ff;
      hneg5_ff  <= hneg4_ff;
      ahneg5_ff <= ahneg4_ff;
      hh5_ff <= (WW'(hh_hh4_ff) <<< (2*HW)) + (WW'(hh_hl4_ff) <<< (HW + 1)) +
                WW'($signed({1'b0, hh_ll4_ff}));
      aq5_ff <= (WW'(aq_hh4_ff) <<< (2*HW)) + (WW'(aq_hl4_ff) <<< HW) +
                (WW'(aq_lh4_ff) <<< HW) + WW'($signed({1'b0, aq_ll4_ff}));
   end

   assign ah_sum = a3_ff + h3_ff;
   assign disc   = hh5_ff - aq5_ff;

   always_comb begin
      pnt_hit = q0neg5_ff || q0z5_ff;
      if (q0neg5_ff && q1neg5_ff) begin
         seg_hit = 1'b0;
      end else if (q0neg5_ff || q1neg5_ff || q0z5_ff || q1z5_ff) begin
         seg_hit = 1'b1;
      end else begin
         seg_hit = hneg5_ff && !ahneg5_ff && !disc[WW-1];
      end
      hit = point_ff ? pnt_hit : seg_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         hit_any_ff <= 1'b0;
      end else begin
         vld_ff <= {vld_ff[4:0], cmd.issue};
         if (cmd.load_query) begin
            hit_any_ff <= 1'b0;
         end else if (vld_ff[5] && hit) begin
            hit_any_ff <= 1'b1;
         end
      end
   end

   assign status.pipe_busy = |vld_ff;
   assign status.hit_any   = hit_any_ff;

endmodule

@@ sv/otcc_ctrl.sv @@
// Controller: operation decode, circle count, query sequencing and response register.
// Depends on otcc_pkg.
module otcc_ctrl #(
   parameter int MAX_CIRCLES = 64,
   parameter int IDX_W       = 6,
   parameter int CNT_W       = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  otcc_pkg::req_type    req,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output otcc_pkg::rsp_type    rsp,
   output otcc_pkg::cmd_type    cmd,
   output logic [IDX_W-1:0]     addr,
   input  otcc_pkg::status_type status
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             free_ff, free_in, drop_ff, drop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   otcc_pkg::rsp_type rsp_ff, rsp_in;
   logic             accept, full;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(MAX_CIRCLES));
   assign addr      = (state_ff == ST_ISSUE) ? idx_ff[IDX_W-1:0] : count_ff[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      free_in      = free_ff;
      drop_in      = drop_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               free_in = 1'b1;
               drop_in = 1'b0;
               state_in = ST_DONE;
               case (req.op)
                  otcc_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  otcc_pkg::OP_ADD: begin
                     if (full) begin
                        drop_in = 1'b1;
                     end else begin
                        cmd.write_entry = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  default: begin
                     cmd.load_query = 1'b1;
                     idx_in = '0;
                     if (count_ff != '0) begin
                        state_in = ST_ISSUE;
                     end
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_in == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               free_in  = !status.hit_any;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Wait until the response register is free or is being taken.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.path_free   = free_ff;
               rsp_in.add_dropped = drop_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      free_ff <= free_in;
      drop_ff <= drop_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ sv/obstacle_table_collision_check.sv @@
// Obstacle table collision checker. Clear and add go from acceptance through the done state to the result.
// A query walks the N stored circles one per cycle through the six-stage pipeline that begins
// with the memory read, then waits for it to drain; an empty table answers without a walk.
// One transaction is processed at a time; a finished result waits in the output register.
// Synchronous active-high reset empties the table and clears all handshake state.
module obstacle_table_collision_check #(
   parameter int MAX_CIRCLES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  otcc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output otcc_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
   localparam int CNT_W = $clog2(MAX_CIRCLES + 1);

   otcc_pkg::cmd_type    cmd;
   otcc_pkg::status_type status;
   logic [IDX_W-1:0]     addr;

   otcc_ctrl #(
      .MAX_CIRCLES(MAX_CIRCLES),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp_data),
      .cmd      (cmd),
      .addr     (addr),
      .status   (status)
   );

   otcc_datapath #(
      .MAX_CIRCLES(MAX_CIRCLES),
      .IDX_W      (IDX_W)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .addr  (addr),
      .status(status)
   );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for obstacle_table_collision_check: directed table, then random ops.
// Each transaction is predicted with exact wide integer arithmetic; depends on otcc_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;
   localparam longint CYCLE_LIMIT = 1000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   otcc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   otcc_pkg::rsp_type rsp_data;

   obstacle_table_collision_check dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Shadow copy of the obstacle table.
   logic signed [15:0] obst_x [TABLE_DEPTH];
   logic signed [15:0] obst_y [TABLE_DEPTH];
   logic [14:0]        obst_r [TABLE_DEPTH];
   int                 obst_count = 0;

   otcc_pkg::rsp_type expected_rsp [$];
   int      error_count = 0;
   longint  cycle_count = 0;
   int      req_idle_pct = 21;
   int      rsp_idle_pct = 70;

   task automatic report_mismatch(input string what);
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic logic point_blocked(input logic signed [15:0] px,
                                          input logic signed [15:0] py,
                                          input int k);
      logic signed [127:0] fx, fy, rr;
      fx = px - obst_x[k];
      fy = py - obst_y[k];
      rr = obst_r[k] * obst_r[k];
      return (fx * fx + fy * fy - rr) <= 0;
   endfunction

   function automatic logic segment_blocked(input logic signed [15:0] sx,
                                            input logic signed [15:0] sy,
                                            input logic signed [15:0] ex,
                                            input logic signed [15:0] ey,
                                            input int k);
      logic signed [127:0] fx, fy, gx, gy, dx, dy, rr, q0, q1, a, h, disc;
      fx = sx - obst_x[k];
      fy = sy - obst_y[k];
      gx = ex - obst_x[k];
      gy = ey - obst_y[k];
      dx = ex - sx;
      dy = ey - sy;
      rr = obst_r[k] * obst_r[k];
      q0 = fx * fx + fy * fy - rr;
      q1 = gx * gx + gy * gy - rr;
      if (q0 < 0 && q1 < 0) return 1'b0;
      if (q0 <= 0 || q1 <= 0) return 1'b1;
      a = dx * dx + dy * dy;
      h = fx * dx + fy * dy;
      if (h >= 0) return 1'b0;
      if (a + h < 0) return 1'b0;
      disc = h * h - a * q0;
      return disc >= 0;
   endfunction

   // Applies one transaction to the shadow table and returns its response.
   function automatic otcc_pkg::rsp_type predict_collision(input otcc_pkg::req_type r);
      otcc_pkg::rsp_type res;
      logic    as_point;
      res.path_free = 1'b1;
      res.add_dropped = 1'b0;
      case (r.op)
         otcc_pkg::OP_CLEAR: begin
            obst_count = 0;
         end
         otcc_pkg::OP_ADD: begin
            if (obst_count >= TABLE_DEPTH) begin
               res.add_dropped = 1'b1;
            end else begin
               obst_x[obst_count] = r.first_x;
               obst_y[obst_count] = r.first_y;
               obst_r[obst_count] = r.circle_radius;
               obst_count++;
            end
         end
         default: begin
            as_point = (r.op == otcc_pkg::OP_POINT) ||
                       (r.first_x == r.second_x && r.first_y == r.second_y);
            for (int k = 0; k < obst_count; k++) begin
               if (as_point ? point_blocked(r.first_x, r.first_y, k)
                            : segment_blocked(r.first_x, r.first_y,
                                              r.second_x, r.second_y, k)) begin
                  res.path_free = 1'b0;
                  break;
               end
            end
         end
      endcase
      return res;
   endfunction

   // Drives one transaction, holding it until accepted; predicted result is queued.
   // Valid stays high after acceptance so that transactions can follow back to back.
   task automatic send_transaction(input otcc_pkg::req_type r, input bit typed,
                                   input otcc_pkg::rsp_type typed_rsp);
      otcc_pkg::rsp_type pred;
      otcc_pkg::rsp_type want;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      pred = predict_collision(r);
      if (typed && pred !== typed_rsp)
         report_mismatch($sformatf("predictor disagrees with table row op %0d", r.op));
      want = typed ? typed_rsp : pred;
      expected_rsp = {expected_rsp, want};
   endtask

   // Drops valid and waits until every expected response has arrived.
   task automatic wait_all_responses();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with nothing expected");
            end else begin
               if (rsp_data.path_free !== expected_rsp[0].path_free)
                  report_mismatch($sformatf("path_free %b expected %b",
                                            rsp_data.path_free, expected_rsp[0].path_free));
               if (rsp_data.add_dropped !== expected_rsp[0].add_dropped)
                  report_mismatch($sformatf("add_dropped %b expected %b",
                                            rsp_data.add_dropped, expected_rsp[0].add_dropped));
               void'(expected_rsp.pop_front());
            end
         end
      end
   end

   function automatic otcc_pkg::req_type make_req(input logic [1:0] op, input int x1,
                                                  input int y1, input int x2, input int y2,
                                                  input int rad);
      otcc_pkg::req_type r;
      r.op = op;
      r.first_x = 16'(x1);
      r.first_y = 16'(y1);
      r.second_x = 16'(x2);
      r.second_y = 16'(y2);
      r.circle_radius = 15'(rad);
      return r;
   endfunction

   function automatic logic signed [15:0] near_coord(input int spread);
      return $signed(16'($urandom_range(2 * spread))) - 16'(spread);
   endfunction

   // Random transaction: mostly geometry near the origin so queries hit and miss.
   function automatic otcc_pkg::req_type random_req();
      otcc_pkg::req_type r;
      logic [95:0]       noise;
      int                pick, spread;
      noise = {$urandom, $urandom, $urandom};
      r = noise[$bits(otcc_pkg::req_type)-1:0];
      pick = $urandom_range(99);
      spread = ($urandom_range(9) == 0) ? 32767 : 2000;
      if (pick < 3) r.op = otcc_pkg::OP_CLEAR;
      else if (pick < 40) r.op = otcc_pkg::OP_ADD;
      else if (pick < 75) r.op = otcc_pkg::OP_SEG;
      else r.op = otcc_pkg::OP_POINT;
      if (spread != 32767) begin
         r.first_x = near_coord(spread);
         r.first_y = near_coord(spread);
         r.second_x = near_coord(spread);
         r.second_y = near_coord(spread);
         r.circle_radius = 15'($urandom_range(600));
      end
      if (r.op == otcc_pkg::OP_SEG && $urandom_range(15) == 0) begin
         r.second_x = r.first_x;
         r.second_y = r.first_y;
      end
      return r;
   endfunction

   typedef struct {
      otcc_pkg::req_type stim;
      bit                typed;
      otcc_pkg::rsp_type outcome;
   } table_row;

   table_row rows [$];

   task automatic add_row(input otcc_pkg::req_type stim, input bit typed,
                          input otcc_pkg::rsp_type outcome);
      table_row row;
      row.stim = stim;
      row.typed = typed;
      row.outcome = outcome;
      rows = {rows, row};
   endtask

   initial begin
      otcc_pkg::rsp_type ok, blocked, dropped;
      ok = '{path_free: 1'b1, add_dropped: 1'b0};
      blocked = '{path_free: 1'b0, add_dropped: 1'b0};
      dropped = '{path_free: 1'b1, add_dropped: 1'b1};

      add_row(make_req(otcc_pkg::OP_SEG, -32768, -32768, 32767, 32767, 0), 1, ok);
      add_row(make_req(otcc_pkg::OP_POINT, 0, 0, 0, 0, 32767), 1, ok);
      add_row(make_req(otcc_pkg::OP_ADD, 0, 0, -1, -1, 160), 1, ok);
      add_row(make_req(otcc_pkg::OP_POINT, 160, 0, 5, 5, 7), 1, blocked);
      add_row(make_req(otcc_pkg::OP_POINT, 161, 0, 0, 0, 0), 1, ok);
      add_row(make_req(otcc_pkg::OP_SEG, -1000, 50, 1000, 50, 0), 1, blocked);
      add_row(make_req(otcc_pkg::OP_SEG, -1000, 500, 1000, 500, 0), 1, ok);
      add_row(make_req(otcc_pkg::OP_SEG, -10, 0, 10, 0, 0), 1, ok);
      add_row(make_req(otcc_pkg::OP_SEG, 160, 0, 160, 0, 0), 1, blocked);
      add_row(make_req(otcc_pkg::OP_SEG, 300, 0, 300, 0, 0), 1, ok);
      add_row(make_req(otcc_pkg::OP_ADD, 32767, 32767, 0, 0, 32767), 1, ok);
      add_row(make_req(otcc_pkg::OP_ADD, -32768, -32768, 0, 0, 0), 1, ok);
      add_row(make_req(otcc_pkg::OP_POINT, -32768, -32768, 0, 0, 0), 1, blocked);
      add_row(make_req(otcc_pkg::OP_SEG, 32767, -32768, -32768, 32767, 0), 0, ok);
      add_row(make_req(otcc_pkg::OP_SEG, 500, 200, 200, 500, 0), 0, ok);
      add_row(make_req(otcc_pkg::OP_CLEAR, -1, -1, -1, -1, 32767), 1, ok);
      add_row(make_req(otcc_pkg::OP_POINT, 0, 0, 0, 0, 0), 1, ok);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_transaction(rows[i].stim, rows[i].typed, rows[i].outcome);
      // Fill the table past full, then query a crowded table.
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_transaction(make_req(otcc_pkg::OP_ADD, 3000 + 10 * i, -3000, 0, 0, 1), 1, ok);
      send_transaction(make_req(otcc_pkg::OP_ADD, 0, 0, 0, 0, 100), 1, dropped);
      send_transaction(make_req(otcc_pkg::OP_POINT, 3630, -3000, 0, 0, 0), 1, blocked);
      send_transaction(make_req(otcc_pkg::OP_SEG, 0, 0, 1, 1, 0), 0, ok);
      send_transaction(make_req(otcc_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 1, ok);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 70 : 0;
         rsp_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 21 : 0;
         for (int n = 0; n < 600; n++) begin
            if (n == 300)
               wait_all_responses();
            send_transaction(random_req(), 0, ok);
         end
      end

      wait_all_responses();
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
sv/otcc_pkg.sv
sv/otcc_datapath.sv
sv/otcc_ctrl.sv
sv/obstacle_table_collision_check.sv
tb/testbench.sv
